FILE: hw/rtl/recd_pkg.sv
package recd_pkg;

  // command codes on the result channel
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_ENTER = 3'd1,
    CMD_EXIT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_LEFT  = 3'd4
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BUTTON_ENABLE    = 2'd0,
    REG_LONG_PRESS_TICKS = 2'd1,
    REG_DEBOUNCE_TICKS   = 2'd2
  } reg_idx_t;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SUM_W   = 16;
  localparam int unsigned HOLD_W  = 17;
  localparam int unsigned TDATA_W = 8;

  localparam logic             BUTTON_ENABLE_RST = 1'b1;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [TICK_W-1:0] DEBOUNCE_RST     = 16'd100;
  localparam logic [3:0]        QUAD_HIST_RST    = 4'h3;

  localparam logic [SUM_W-1:0] SUM_RIGHT = 16'h0004;
  localparam logic [SUM_W-1:0] SUM_LEFT  = 16'hFFFC;

  // signed step per transition history; 14 marks a bounce and is added as is
  function automatic logic [SUM_W-1:0] step_delta(input logic [3:0] hist);
    logic [SUM_W-1:0] d;
    d = '0;
    case (hist)
      4'd1, 4'd7, 4'd8, 4'd14: d = 16'hFFFF;
      4'd2, 4'd4, 4'd11, 4'd13: d = 16'h0001;
      4'd3, 4'd6, 4'd9, 4'd12: d = 16'd14;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

FILE: hw/rtl/rotary_encoder_command_decoder.sv
// Rotary encoder command decoder. Each input transaction is one tick of pin
// samples (quadrature lines a/b and the active-low push button) and yields
// exactly one result transaction carrying a command (none, enter, exit,
// right, left) and a beep flag. One tick is accepted every clock while the
// result side keeps taking results; a result is offered once its tick has
// moved from the input register to the result register, and the decoder
// state is updated as the tick moves between them.
// Backpressure on the result side stalls the input side once both registers
// are full. Configuration writes on cfg_* take effect on the next clock and
// are meant for idle periods.
module rotary_encoder_command_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [recd_pkg::TDATA_W-1:0]  in_tdata,   // [0] line_a, [1] line_b,
                                                    // [2] button_level, rest zero
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [recd_pkg::TDATA_W-1:0]  out_tdata,  // [2:0] command, [3] beep,
                                                    // rest zero
  // configuration
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [recd_pkg::TICK_W-1:0]   cfg_wdata
);

  // configuration registers
  logic                        button_enable_r;
  logic [recd_pkg::TICK_W-1:0] long_press_ticks_r;
  logic [recd_pkg::TICK_W-1:0] debounce_ticks_r;

  // input register stage
  logic       in_valid_r;
  logic       line_a_r, line_b_r, button_level_r;

  // result register
  logic                 out_valid_r;
  recd_pkg::cmd_t       out_cmd_r;
  logic                 out_beep_r;

  // decoder state
  logic [3:0]                  quad_hist_r, quad_hist_nxt;
  logic [recd_pkg::SUM_W-1:0]  step_sum_r, step_sum_nxt;
  recd_pkg::cmd_t              last_cmd_r, last_cmd_nxt;
  logic                        holding_r, holding_nxt;
  logic [recd_pkg::HOLD_W-1:0] hold_count_r, hold_count_nxt;
  logic                        deb_pending_r, deb_pending_nxt;
  logic [recd_pkg::TICK_W-1:0] deb_count_r, deb_count_nxt;
  recd_pkg::cmd_t              cmd_nxt;

  // handshake: the result register frees when empty or being taken
  logic out_free;
  logic stage_adv;

  assign out_free  = !out_valid_r || out_tready;
  assign stage_adv = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_beep_r, out_cmd_r};

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      button_enable_r    <= recd_pkg::BUTTON_ENABLE_RST;
      long_press_ticks_r <= recd_pkg::LONG_PRESS_RST;
      debounce_ticks_r   <= recd_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (recd_pkg::reg_idx_t'(cfg_index))
        recd_pkg::REG_BUTTON_ENABLE:    button_enable_r    <= cfg_wdata[0];
        recd_pkg::REG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_wdata;
        recd_pkg::REG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_wdata;
        default: ;  // unmapped index, write is dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      line_a_r       <= in_tdata[0];
      line_b_r       <= in_tdata[1];
      button_level_r <= in_tdata[2];
    end
  end

  // one tick of the decoder
  always_comb begin
    logic                       proceed;
    logic [recd_pkg::SUM_W-1:0] sum_add;
    logic [recd_pkg::HOLD_W-1:0] hold_inc;
    logic [3:0]                 hist;

    quad_hist_nxt   = quad_hist_r;
    step_sum_nxt    = step_sum_r;
    last_cmd_nxt    = last_cmd_r;
    holding_nxt     = holding_r;
    hold_count_nxt  = hold_count_r;
    deb_pending_nxt = deb_pending_r;
    deb_count_nxt   = deb_count_r;
    cmd_nxt         = recd_pkg::CMD_NONE;
    proceed         = 1'b1;
    hold_inc        = hold_count_r + 1'b1;
    hist            = {quad_hist_r[1:0], line_a_r, line_b_r};
    sum_add         = step_sum_r + recd_pkg::step_delta(hist);

    if (holding_r) begin
      // button wins while held, rotation is not sampled
      if (button_level_r) begin
        holding_nxt  = 1'b0;
        cmd_nxt      = recd_pkg::CMD_ENTER;
        last_cmd_nxt = recd_pkg::CMD_ENTER;
      end else begin
        hold_count_nxt = hold_inc;
        if (hold_inc > {1'b0, long_press_ticks_r}) begin
          holding_nxt     = 1'b0;
          deb_pending_nxt = 1'b1;
          deb_count_nxt   = '0;
          cmd_nxt         = recd_pkg::CMD_EXIT;
          last_cmd_nxt    = recd_pkg::CMD_EXIT;
        end
      end
    end else begin
      // post long-press hold-off
      if (button_enable_r && deb_pending_r) begin
        if (deb_count_r < debounce_ticks_r) begin
          deb_count_nxt = deb_count_r + 1'b1;
          proceed       = 1'b0;
        end else begin
          deb_pending_nxt = 1'b0;
          deb_count_nxt   = '0;
        end
      end
      if (proceed) begin
        if (button_enable_r && !button_level_r && last_cmd_r == recd_pkg::CMD_NONE) begin
          holding_nxt    = 1'b1;
          hold_count_nxt = '0;
        end else begin
          quad_hist_nxt = hist;
          if (sum_add[1:0] != 2'b00) begin
            step_sum_nxt = sum_add;
          end else begin
            // any multiple of four clears the sum; only +4 and -4 give a step
            step_sum_nxt = '0;
            if (sum_add == recd_pkg::SUM_RIGHT) begin
              cmd_nxt = recd_pkg::CMD_RIGHT;
            end else if (sum_add == recd_pkg::SUM_LEFT) begin
              cmd_nxt = recd_pkg::CMD_LEFT;
            end
          end
          last_cmd_nxt = cmd_nxt;
        end
      end
    end
  end

  // decoder state, updated once per tick as it moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quad_hist_r   <= recd_pkg::QUAD_HIST_RST;
      step_sum_r    <= '0;
      last_cmd_r    <= recd_pkg::CMD_NONE;
      holding_r     <= 1'b0;
      hold_count_r  <= '0;
      deb_pending_r <= 1'b0;
      deb_count_r   <= '0;
    end else if (stage_adv) begin
      quad_hist_r   <= quad_hist_nxt;
      step_sum_r    <= step_sum_nxt;
      last_cmd_r    <= last_cmd_nxt;
      holding_r     <= holding_nxt;
      hold_count_r  <= hold_count_nxt;
      deb_pending_r <= deb_pending_nxt;
      deb_count_r   <= deb_count_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv) begin
      out_cmd_r  <= cmd_nxt;
      out_beep_r <= (cmd_nxt == recd_pkg::CMD_ENTER) || (cmd_nxt == recd_pkg::CMD_EXIT);
    end
  end

endmodule

FILE: hw/rtl/recd_checker.sv
module recd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [recd_pkg::TDATA_W-1:0] out_tdata
);

  // beep goes with enter and exit only
  a_beep_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3] ==
      ((out_tdata[2:0] == recd_pkg::CMD_ENTER) || (out_tdata[2:0] == recd_pkg::CMD_EXIT))))
    else $error("beep does not match command");

  // only defined command codes and zero padding leave the block
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] <= recd_pkg::CMD_LEFT && out_tdata[7:4] == 4'b0000))
    else $error("undefined command code or nonzero padding");

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");

  // nothing is offered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rotary_encoder_command_decoder recd_checker u_recd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = 8;        // quiet time after the expected queue drains
  localparam int STALL_CYCLES  = 200;      // long receiver hold-off
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_TICKS  = 750;

  // expected decoder output for one tick
  typedef struct packed {
    recd_pkg::cmd_t cmd;
    logic           beep;
  } tick_result_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [7:0]         in_tdata;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               cfg_we;
  recd_pkg::reg_idx_t cfg_index;
  logic [15:0]        cfg_wdata;

  // traffic shaping knobs shared by the sender task and the receiver process
  bit   tx_idle_en;
  bit   rx_idle_en;
  logic rx_block;
  int   rx_wait;

  // knob position as the sender sees it, 0..3 along the clockwise gray sequence
  int quad_pos;

  // decoder mirror: settings and state as the block should hold them
  logic           set_btn_en;
  logic [15:0]    set_long_ticks;
  logic [15:0]    set_db_ticks;
  logic [3:0]     pos_hist;
  logic [15:0]    pos_sum;
  recd_pkg::cmd_t prev_cmd;
  logic           in_hold;
  logic [16:0]    held_ticks;
  logic           lockout_armed;
  logic [15:0]    lockout_ticks;

  tick_result_t expected_cmds[$];
  int           mismatches;
  int           results_seen;

  rotary_encoder_command_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [0] line_a, [1] line_b, [2] button_level
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [2:0] command, [3] beep
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // signed step for a 4-bit transition history {prev a, prev b, a, b};
  // impossible double transitions count as bounce and add 14
  function automatic logic [15:0] quad_delta(input logic [3:0] h);
    int d;
    case (h)
      4'd0, 4'd5, 4'd10, 4'd15: d = 0;
      4'd2, 4'd4, 4'd11, 4'd13: d = 1;
      4'd1, 4'd7, 4'd8, 4'd14:  d = -1;
      default:                  d = 14;
    endcase
    return d[15:0];
  endfunction

  // quadrature accumulation; a full detent is a sum of exactly +4 or -4,
  // any other multiple of four just clears the sum
  function automatic recd_pkg::cmd_t track_rotation(input logic a, input logic b);
    recd_pkg::cmd_t c;
    c = recd_pkg::CMD_NONE;
    pos_hist = {pos_hist[1:0], a, b};
    pos_sum  = pos_sum + quad_delta(pos_hist);
    if (pos_sum[1:0] == 2'b00) begin
      if (pos_sum == recd_pkg::SUM_RIGHT) begin
        c = recd_pkg::CMD_RIGHT;
      end else if (pos_sum == recd_pkg::SUM_LEFT) begin
        c = recd_pkg::CMD_LEFT;
      end
      pos_sum = '0;
    end
    return c;
  endfunction

  // one tick of the decoder: hold tracking, lockout after a long press,
  // press start, and rotation otherwise
  function automatic tick_result_t decode_tick(input logic a, input logic b, input logic btn);
    tick_result_t   r;
    recd_pkg::cmd_t c;
    logic           go;
    c = recd_pkg::CMD_NONE;
    if (in_hold) begin
      // button checked even if the enable was cleared during the hold
      if (btn) begin
        in_hold  = 1'b0;
        c        = recd_pkg::CMD_ENTER;
        prev_cmd = c;
      end else begin
        held_ticks = held_ticks + 17'd1;
        if (held_ticks > {1'b0, set_long_ticks}) begin
          in_hold       = 1'b0;
          lockout_armed = 1'b1;
          lockout_ticks = '0;
          c             = recd_pkg::CMD_EXIT;
          prev_cmd      = c;
        end
      end
    end else begin
      go = 1'b1;
      // a disabled button freezes a pending lockout
      if (set_btn_en && lockout_armed) begin
        if (lockout_ticks < set_db_ticks) begin
          lockout_ticks = lockout_ticks + 16'd1;
          go = 1'b0;
        end else begin
          lockout_armed = 1'b0;
          lockout_ticks = '0;
        end
      end
      if (go) begin
        if (set_btn_en && !btn && prev_cmd == recd_pkg::CMD_NONE) begin
          in_hold    = 1'b1;
          held_ticks = '0;
        end else begin
          c        = track_rotation(a, b);
          prev_cmd = c;
        end
      end
    end
    r.cmd  = c;
    r.beep = (c == recd_pkg::CMD_ENTER) || (c == recd_pkg::CMD_EXIT);
    return r;
  endfunction

  // mirror update and result check, all on pre-edge values
  always @(posedge clk) begin : scoreboard
    tick_result_t want;
    if (!rst_n) begin
      set_btn_en     = recd_pkg::BUTTON_ENABLE_RST;
      set_long_ticks = recd_pkg::LONG_PRESS_RST;
      set_db_ticks   = recd_pkg::DEBOUNCE_RST;
      pos_hist       = recd_pkg::QUAD_HIST_RST;
      pos_sum        = '0;
      prev_cmd       = recd_pkg::CMD_NONE;
      in_hold        = 1'b0;
      held_ticks     = '0;
      lockout_armed  = 1'b0;
      lockout_ticks  = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          recd_pkg::REG_BUTTON_ENABLE:    set_btn_en     = cfg_wdata[0];
          recd_pkg::REG_LONG_PRESS_TICKS: set_long_ticks = cfg_wdata;
          recd_pkg::REG_DEBOUNCE_TICKS:   set_db_ticks   = cfg_wdata;
          default: ;
        endcase
      end
      // push before popping: a tick never produces its result at the same edge
      if (in_tvalid && in_tready) begin
        expected_cmds.push_back(decode_tick(in_tdata[0], in_tdata[1], in_tdata[2]));
      end
      if (out_tvalid && out_tready) begin
        if (expected_cmds.size() == 0) begin
          if (mismatches < 10) begin
            $display("mismatch: result %0d with nothing expected, data %h",
                     results_seen, out_tdata);
          end
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (out_tdata[2:0] !== want.cmd || out_tdata[3] !== want.beep ||
              out_tdata[7:4] !== 4'b0) begin
            if (mismatches < 10) begin
              $display("mismatch: result %0d expected cmd %s beep %0b, got cmd %0d beep %0b pad %h",
                       results_seen, want.cmd.name(), want.beep,
                       out_tdata[2:0], out_tdata[3], out_tdata[7:4]);
            end
            mismatches++;
          end
        end
        results_seen++;
      end
    end
  end

  // result side: random stall before each transaction, or a forced hold-off
  always @(posedge clk) begin : rx_side
    logic ready_nx;
    if (!rst_n) begin
      ready_nx = 1'b0;
      rx_wait  = 0;
    end else if (rx_block) begin
      ready_nx = 1'b0;
    end else if (out_tready && out_tvalid) begin
      rx_wait  = rx_idle_en ? $urandom_range(0, 6) : 0;
      ready_nx = (rx_wait == 0);
    end else if (!out_tready) begin
      if (rx_wait > 0) rx_wait--;
      ready_nx = (rx_wait == 0);
    end else begin
      ready_nx = 1'b1;
    end
    out_tready <= ready_nx;
  end

  // offer one tick after a random gap and wait for the transaction
  task automatic send_tick(input logic a, input logic b, input logic btn);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, btn, b, a};
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
  endtask

  // move the knob by dir gray steps (+1 clockwise, -1 back, 2 is a bounce)
  task automatic step_knob(input int dir, input logic btn);
    logic [1:0] ab;
    quad_pos = (quad_pos + dir + 4) % 4;
    case (quad_pos)
      0:       ab = 2'b00;
      1:       ab = 2'b10;
      2:       ab = 2'b11;
      default: ab = 2'b01;
    endcase
    send_tick(ab[1], ab[0], btn);
  endtask

  // press for held_for ticks after the starting one, knob wobbling, then release
  task automatic press_button(input int held_for);
    step_knob(0, 1'b0);
    repeat (held_for) step_knob($urandom_range(0, 2) - 1, 1'b0);
    step_knob(0, 1'b1);
  endtask

  // stop offering and wait for the block to go quiet
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes all three registers, one per clock
  task automatic load_settings(input logic en, input logic [15:0] long_t,
                               input logic [15:0] db_t);
    cfg_we    <= 1'b1;
    cfg_index <= recd_pkg::REG_BUTTON_ENABLE;
    cfg_wdata <= {15'b0, en};
    @(posedge clk);
    cfg_index <= recd_pkg::REG_LONG_PRESS_TICKS;
    cfg_wdata <= long_t;
    @(posedge clk);
    cfg_index <= recd_pkg::REG_DEBOUNCE_TICKS;
    cfg_wdata <= db_t;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // reset settings: detents both ways, bounces, a hold with rotation ignored,
  // a press right after a command, and a short press giving enter
  task automatic test_directed();
    repeat (4) step_knob(1, 1'b1);
    repeat (4) step_knob(-1, 1'b1);
    step_knob(2, 1'b1);
    step_knob(2, 1'b1);
    step_knob(0, 1'b1);
    step_knob(0, 1'b0);
    step_knob(1, 1'b0);
    step_knob(-1, 1'b0);
    step_knob(0, 1'b1);
    // enter was last, so a press is decoded as rotation once before it counts
    step_knob(0, 1'b0);
    step_knob(0, 1'b0);
    step_knob(0, 1'b1);
    repeat (4) step_knob(1, 1'b0);
    step_knob(0, 1'b1);
    settle();
  endtask

  // zero long-press limit and zero lockout, then small limits on both sides
  task automatic test_press_limits();
    load_settings(1'b1, 16'd0, 16'd0);
    press_button(1);
    step_knob(0, 1'b1);
    step_knob(1, 1'b1);
    settle();
    load_settings(1'b1, 16'd3, 16'd2);
    step_knob(0, 1'b1);
    press_button(5);
    repeat (4) step_knob(1, 1'b1);
    step_knob(0, 1'b1);
    // held exactly at the limit still gives enter
    press_button(3);
    step_knob(0, 1'b1);
    settle();
  endtask

  // enable cleared during a hold and while a lockout is pending
  task automatic test_button_disable();
    load_settings(1'b1, 16'd1, 16'd5);
    step_knob(0, 1'b1);
    step_knob(0, 1'b0);
    settle();
    load_settings(1'b0, 16'd1, 16'd5);
    step_knob(0, 1'b0);
    step_knob(0, 1'b1);
    settle();
    load_settings(1'b1, 16'd1, 16'd5);
    step_knob(0, 1'b1);
    press_button(4);
    settle();
    load_settings(1'b0, 16'd1, 16'd5);
    repeat (4) step_knob(-1, 1'b0);
    repeat (3) step_knob(1, 1'b1);
    settle();
    load_settings(1'b1, 16'd1, 16'd5);
    repeat (8) step_knob(0, 1'b1);
    press_button(0);
    settle();
  endtask

  // longer limits that carry through the low counter bits: a hold into exit,
  // then the full lockout; run back to back so it stays short in cycles
  task automatic test_extreme_counts();
    load_settings(1'b1, 16'd100, 16'd64);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    step_knob(0, 1'b1);
    repeat (102) step_knob(0, 1'b0);
    repeat (64) step_knob(1, 1'b1);
    press_button(2);
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // rotation only: steps back, then a run of bounces adding 14 each; a sum
  // that went below zero wraps back across it
  task automatic test_sum_wrap();
    load_settings(1'b0, 16'd1000, 16'd100);
    tx_idle_en = 1'b0;
    step_knob(0, 1'b1);
    repeat (6) step_knob(-1, 1'b1);
    repeat (40) step_knob(2, 1'b1);
    repeat (8) step_knob(-1, 1'b1);
    settle();
    tx_idle_en = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    load_settings(1'b1, 16'd4, 16'd3);
    tx_idle_en = 1'b0;
    fork
      begin
        rx_block <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk);
        rx_block <= 1'b0;
      end
      begin
        repeat (20) step_knob(1, 1'b1);
        press_button(2);
        press_button(7);
        repeat (40) step_knob($urandom_range(0, 3) - 1, 1'($urandom_range(0, 1)));
      end
    join
    tx_idle_en = 1'b1;
    settle();
  endtask

  // mostly well-formed detents and presses with random content, some noise;
  // settings change between phases
  task automatic test_random_traffic(input int total);
    int phase;
    int goal;
    int sent;
    int r;
    logic en;
    logic [15:0] long_t;
    logic [15:0] db_t;
    for (phase = 0; phase < 6; phase++) begin
      en     = (phase == 0) ? 1'b1 : ($urandom_range(0, 4) != 0);
      long_t = (phase == 0) ? 16'd0 : 16'($urandom_range(0, 10));
      db_t   = (phase == 0) ? 16'd0 : 16'($urandom_range(0, 10));
      if ($urandom_range(0, 5) == 0) long_t = 16'($urandom_range(0, 16'hFFFF));
      load_settings(en, long_t, db_t);
      goal = total / 6;
      sent = 0;
      while (sent < goal) begin
        if ($urandom_range(0, 15) == 0) tx_idle_en = ~tx_idle_en;
        if ($urandom_range(0, 15) == 0) rx_idle_en = ~rx_idle_en;
        r = $urandom_range(0, 9);
        case (r)
          0, 1, 2, 3: begin
            // detent, sometimes with a pause between gray steps
            r = $urandom_range(0, 1) ? 1 : -1;
            repeat (4) begin
              step_knob(r, 1'b1);
              sent++;
              if ($urandom_range(0, 3) == 0) begin
                step_knob(0, 1'b1);
                sent++;
              end
            end
          end
          4: begin
            step_knob(2, 1'b1);
            sent++;
          end
          5, 6: begin
            r = $urandom_range(0, 14);
            press_button(r);
            sent += r + 2;
          end
          7: begin
            r = $urandom_range(1, 3);
            repeat (r) step_knob(0, 1'b1);
            sent += r;
          end
          default: begin
            r = $urandom_range(0, 3);
            step_knob((r == 3) ? 2 : r - 1, 1'($urandom_range(0, 1)));
            sent++;
          end
        endcase
      end
      settle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= recd_pkg::REG_BUTTON_ENABLE;
    cfg_wdata  <= '0;
    rx_block   <= 1'b0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    quad_pos    = 2;        // reset history says both lines were high
    mismatches  = 0;
    results_seen = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_press_limits();
    test_button_disable();
    test_extreme_counts();
    test_sum_wrap();
    test_backpressure();
    test_random_traffic(RANDOM_TICKS);

    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule
